// ===== design/dds_pkg.sv =====
// Shared types, constants and helper functions for the diffuse direction sampler.
package dds_pkg;

    localparam int ANG_W = 32;

    typedef struct packed {
        logic [15:0] rand_polar;
        logic [15:0] rand_turn;
        logic        final_sample;
    } dds_item_t;

    localparam logic [1:0] REG_NORMAL_X = 2'd0;
    localparam logic [1:0] REG_NORMAL_Y = 2'd1;
    localparam logic [1:0] REG_NORMAL_Z = 2'd2;

    function automatic logic [31:0] atan_entry(input int idx);
        logic [31:0] r;
        begin
            unique case (idx)
                0: r = 32'h20000000;  1: r = 32'h12E4051E;  2: r = 32'h09FB385B;
                3: r = 32'h051111D4;  4: r = 32'h028B0D43;  5: r = 32'h0145D7E1;
                6: r = 32'h00A2F61E;  7: r = 32'h00517C55;  8: r = 32'h0028BE53;
                9: r = 32'h00145F2F; 10: r = 32'h000A2F98; 11: r = 32'h000517CC;
                12: r = 32'h00028BE6; 13: r = 32'h000145F3; 14: r = 32'h0000A2F9;
                15: r = 32'h0000517D; 16: r = 32'h000028BE; 17: r = 32'h0000145F;
                18: r = 32'h00000A30; 19: r = 32'h00000518; 20: r = 32'h0000028C;
                21: r = 32'h00000146; 22: r = 32'h000000A3; 23: r = 32'h00000051;
                24: r = 32'h00000029; 25: r = 32'h00000014; 26: r = 32'h0000000A;
                27: r = 32'h00000005; 28: r = 32'h00000003; 29: r = 32'h00000001;
                30: r = 32'h00000001;
                default: r = 32'h00000000;
            endcase
            return r;
        end
    endfunction

endpackage

// ===== design/dds_sqrt.sv =====
// Pipelined floor integer square root of a 64-bit value, one digit per stage.
module dds_sqrt
    import dds_pkg::*;
#(
    parameter int TAG_W = 8
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             en,
    input  logic [63:0]      radicand,
    input  logic [TAG_W-1:0] tag_in,
    output logic [31:0]      root,
    output logic [TAG_W-1:0] tag_out
);
    localparam int STAGES = 32;

    logic [63:0]      v_reg   [STAGES+1];
    logic [63:0]      r_reg   [STAGES+1];
    logic [TAG_W-1:0] tag_reg [STAGES+1];

    always_comb
    begin
        v_reg[0]   = radicand;
        r_reg[0]   = '0;
        tag_reg[0] = tag_in;
    end

    for (genvar k = 0; k < STAGES; k++)
    begin : g_stage
        localparam logic [63:0] BIT = 64'd1 << (62 - 2 * k);
        logic [63:0] v_next;
        logic [63:0] r_next;
        logic [63:0] trial;
        always_comb
        begin
            trial = r_reg[k] + BIT;
            if (v_reg[k] >= trial)
            begin
                v_next = v_reg[k] - trial;
                r_next = (r_reg[k] >> 1) + BIT;
            end
            else
            begin
                v_next = v_reg[k];
                r_next = r_reg[k] >> 1;
            end
        end
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                v_reg[k+1] <= v_next;
                r_reg[k+1] <= r_next;
            end
        end
        // tags carry valid flags, so they start cleared
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                tag_reg[k+1] <= '0;
            else if (en)
                tag_reg[k+1] <= tag_reg[k];
        end
    end

    assign root    = r_reg[STAGES][31:0];
    assign tag_out = tag_reg[STAGES];

endmodule

// ===== design/dds_core.sv =====
// Back end: one long enable-gated pipeline computing a direction from one item.
module dds_core
    import dds_pkg::*;
#(
    parameter int FRAC_BITS    = 15,
    parameter int CORDIC_STEPS = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        en,
    input  logic        in_valid,
    input  dds_item_t   item,
    input  logic [15:0] normal_x,
    input  logic [15:0] normal_y,
    input  logic [15:0] normal_z,
    output logic        out_valid,
    output logic [15:0] dir_x,
    output logic [15:0] dir_y,
    output logic [15:0] dir_z,
    output logic        final_vector
);
    // working width holds products of two QF values plus headroom
    localparam int W   = 2 * FRAC_BITS + 8;
    localparam int CS  = CORDIC_STEPS;
    localparam logic signed [W-1:0] ONE = W'(1) <<< FRAC_BITS;

    typedef logic signed [W-1:0] val_t;

    // every multiplicand lies in [-1, 1], so F+2 bits per operand suffice
    function automatic logic signed [2*W-1:0] qprod(input val_t a, input val_t b);
        logic signed [FRAC_BITS+1:0]   an;
        logic signed [FRAC_BITS+1:0]   bn;
        logic signed [2*FRAC_BITS+3:0] p;
        begin
            an = a[FRAC_BITS+1:0];
            bn = b[FRAC_BITS+1:0];
            p  = an * bn;
            return (2*W)'(p);
        end
    endfunction

    // The data path is written as a series of stages; side-band fields
    // ride along in a delay line keyed to the stage.
    // Stage A: r1, s1 = sqrt(1 - r1^2)
    val_t r1_a;
    logic [63:0] rad_a;
    always_comb
    begin
        r1_a  = val_t'((64'(item.rand_polar) << FRAC_BITS) >> 16);
        rad_a = 64'(ONE * ONE - qprod(r1_a, r1_a));
    end

    localparam int TAG1 = W + 16 + 1 + 1;
    logic [TAG1-1:0] t1_in, t1_out;
    logic [31:0] s1_root;
    assign t1_in = {r1_a, item.rand_turn, item.final_sample, in_valid};
    dds_sqrt #(.TAG_W(TAG1)) u_sq1 (
        .clk(clk), .rst_n(rst_n), .en(en), .radicand(rad_a), .tag_in(t1_in),
        .root(s1_root), .tag_out(t1_out)
    );

    // Stage B: vectoring CORDIC for acos
    val_t        vx_reg [CS+1];
    val_t        vy_reg [CS+1];
    logic [63:0] vz_reg [CS+1];
    logic [15:0] vt_reg [CS+1];
    logic        vf_reg [CS+1];
    logic        vv_reg [CS+1];
    always_comb
    begin
        vx_reg[0] = val_t'(t1_out[TAG1-1 -: W]);
        vy_reg[0] = val_t'({1'b0, s1_root});
        vz_reg[0] = '0;
        vt_reg[0] = t1_out[17:2];
        vf_reg[0] = t1_out[1];
        vv_reg[0] = t1_out[0];
    end
    for (genvar i = 0; i < CS; i++)
    begin : g_vec
        localparam int S = i % 32;
        localparam logic [63:0] A = 64'(atan_entry(S));
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                if (vy_reg[i] >= 0)
                begin
                    vx_reg[i+1] <= vx_reg[i] + (vy_reg[i] >>> S);
                    vy_reg[i+1] <= vy_reg[i] - (vx_reg[i] >>> S);
                    vz_reg[i+1] <= vz_reg[i] + A;
                end
                else
                begin
                    vx_reg[i+1] <= vx_reg[i] - (vy_reg[i] >>> S);
                    vy_reg[i+1] <= vy_reg[i] + (vx_reg[i] >>> S);
                    vz_reg[i+1] <= vz_reg[i] - A;
                end
                vt_reg[i+1] <= vt_reg[i];
                vf_reg[i+1] <= vf_reg[i];
            end
        end
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                vv_reg[i+1] <= 1'b0;
            else if (en)
                vv_reg[i+1] <= vv_reg[i];
        end
    end

    // Stage C: u and b = sqrt(1 - u^2)
    logic signed [63:0] ang_c;
    val_t u_c;
    logic [63:0] rad_c;
    always_comb
    begin
        ang_c = $signed(vz_reg[CS]) >>> (30 - FRAC_BITS);
        if (ang_c < 0)
            u_c = '0;
        else if (ang_c > 64'(ONE))
            u_c = ONE;
        else
            u_c = val_t'(ang_c);
        rad_c = 64'(ONE * ONE - qprod(u_c, u_c));
    end

    localparam int TAG2 = W + 16 + 1 + 1;
    logic [TAG2-1:0] t2_in, t2_out;
    logic [31:0] b_root;
    assign t2_in = {u_c, vt_reg[CS], vf_reg[CS], vv_reg[CS]};
    dds_sqrt #(.TAG_W(TAG2)) u_sq2 (
        .clk(clk), .rst_n(rst_n), .en(en), .radicand(rad_c), .tag_in(t2_in),
        .root(b_root), .tag_out(t2_out)
    );

    // Stage D: rotating CORDIC for sin/cos(theta)
    val_t        rx_reg [CS+1];
    val_t        ry_reg [CS+1];
    logic signed [33:0] rd_reg [CS+1];
    logic        rfl_reg [CS+1];
    val_t        ru_reg [CS+1];
    val_t        rb_reg [CS+1];
    logic        rf_reg [CS+1];
    logic        rv_reg [CS+1];
    localparam val_t K0 = val_t'((64'h9B74EDA8 + (64'd1 << (31 - FRAC_BITS)))
                                 >> (32 - FRAC_BITS));
    logic signed [33:0] d0;
    always_comb
    begin
        d0 = 34'(signed'({t2_out[17:2], 16'h0}));
        rfl_reg[0] = 1'b0;
        if (d0 > 34'sh40000000)
        begin
            d0 = d0 - 34'sh80000000;
            rfl_reg[0] = 1'b1;
        end
        else if (d0 < -34'sh40000000)
        begin
            d0 = d0 + 34'sh80000000;
            rfl_reg[0] = 1'b1;
        end
        rd_reg[0] = d0;
        rx_reg[0] = K0;
        ry_reg[0] = '0;
        ru_reg[0] = val_t'(t2_out[TAG2-1 -: W]);
        rb_reg[0] = val_t'({1'b0, b_root});
        rf_reg[0] = t2_out[1];
        rv_reg[0] = t2_out[0];
    end
    for (genvar i = 0; i < CS; i++)
    begin : g_rot
        localparam int S = i % 32;
        localparam logic signed [33:0] A = 34'(atan_entry(S));
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                if (rd_reg[i] >= 0)
                begin
                    rx_reg[i+1] <= rx_reg[i] - (ry_reg[i] >>> S);
                    ry_reg[i+1] <= ry_reg[i] + (rx_reg[i] >>> S);
                    rd_reg[i+1] <= rd_reg[i] - A;
                end
                else
                begin
                    rx_reg[i+1] <= rx_reg[i] + (ry_reg[i] >>> S);
                    ry_reg[i+1] <= ry_reg[i] - (rx_reg[i] >>> S);
                    rd_reg[i+1] <= rd_reg[i] + A;
                end
                rfl_reg[i+1] <= rfl_reg[i];
                ru_reg[i+1]  <= ru_reg[i];
                rb_reg[i+1]  <= rb_reg[i];
                rf_reg[i+1]  <= rf_reg[i];
            end
        end
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                rv_reg[i+1] <= 1'b0;
            else if (en)
                rv_reg[i+1] <= rv_reg[i];
        end
    end

    // Stage E: clamp and local vector
    val_t ct_e, st_e, y_e_next, z_e_next;
    val_t x_e_reg, y_e_reg, z_e_reg;
    logic f_e_reg, v_e_reg;
    logic signed [2*W-1:0] py, pz;
    always_comb
    begin
        ct_e = rfl_reg[CS] ? -rx_reg[CS] : rx_reg[CS];
        st_e = rfl_reg[CS] ? -ry_reg[CS] : ry_reg[CS];
        if (ct_e > ONE) ct_e = ONE;
        if (ct_e < -ONE) ct_e = -ONE;
        if (st_e > ONE) st_e = ONE;
        if (st_e < -ONE) st_e = -ONE;
        py = qprod(rb_reg[CS], st_e);
        pz = qprod(rb_reg[CS], ct_e);
        y_e_next = val_t'(py >>> FRAC_BITS);
        z_e_next = val_t'(pz >>> FRAC_BITS);
    end
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_e_reg <= ru_reg[CS];
            y_e_reg <= y_e_next;
            z_e_reg <= z_e_next;
            f_e_reg <= rf_reg[CS];
        end
    end
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_e_reg <= 1'b0;
        else if (en)
            v_e_reg <= rv_reg[CS];
    end

    // Frame terms from the normal: computed from quiet config registers.
    val_t nx_f, ny_f, nz_f;
    val_t cp_f, sp_f, cy_f, sy_f;
    always_comb
    begin
        if (FRAC_BITS >= 15)
        begin
            nx_f = val_t'($signed(normal_x)) <<< (FRAC_BITS - 15);
            ny_f = val_t'($signed(normal_y)) <<< (FRAC_BITS - 15);
            nz_f = val_t'($signed(normal_z)) <<< (FRAC_BITS - 15);
        end
        else
        begin
            nx_f = val_t'($signed(normal_x)) >>> (15 - FRAC_BITS);
            ny_f = val_t'($signed(normal_y)) >>> (15 - FRAC_BITS);
            nz_f = val_t'($signed(normal_z)) >>> (15 - FRAC_BITS);
        end
    end
    dds_frame #(.FRAC_BITS(FRAC_BITS), .CORDIC_STEPS(CORDIC_STEPS)) u_frame (
        .clk(clk), .rst_n(rst_n), .nx(nx_f), .ny(ny_f), .nz(nz_f),
        .cp(cp_f), .sp(sp_f), .cy(cy_f), .sy(sy_f)
    );

    // Stage F: products of frame terms
    val_t cpcy_reg, cysp_reg, cpsy_reg, spsy_reg, cp_reg, sp_reg, cy_reg, sy_reg;
    val_t xf_reg, yf_reg, zf_reg;
    logic ff_reg, vf_f_reg;
    logic signed [2*W-1:0] p1, p2, p3, p4;
    assign p1 = qprod(cp_f, cy_f);
    assign p2 = qprod(cy_f, sp_f);
    assign p3 = qprod(cp_f, sy_f);
    assign p4 = qprod(sp_f, sy_f);
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            cpcy_reg <= val_t'(p1 >>> FRAC_BITS);
            cysp_reg <= val_t'(p2 >>> FRAC_BITS);
            cpsy_reg <= val_t'(p3 >>> FRAC_BITS);
            spsy_reg <= val_t'(p4 >>> FRAC_BITS);
            cp_reg <= cp_f;  sp_reg <= sp_f;  cy_reg <= cy_f;  sy_reg <= sy_f;
            xf_reg <= x_e_reg;  yf_reg <= y_e_reg;  zf_reg <= z_e_reg;
            ff_reg <= f_e_reg;
        end
    end
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vf_f_reg <= 1'b0;
        else if (en)
            vf_f_reg <= v_e_reg;
    end

    // Stage G: the eight final products
    val_t g_reg [8];
    logic fg_reg, vg_reg;
    function automatic val_t qmul(input val_t a, input val_t b);
        logic signed [2*W-1:0] p;
        begin
            p = qprod(a, b);
            return val_t'(p >>> FRAC_BITS);
        end
    endfunction
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            g_reg[0] <= qmul(cpcy_reg, xf_reg);
            g_reg[1] <= qmul(sy_reg, yf_reg);
            g_reg[2] <= qmul(cysp_reg, zf_reg);
            g_reg[3] <= qmul(cpsy_reg, xf_reg);
            g_reg[4] <= qmul(cy_reg, yf_reg);
            g_reg[5] <= qmul(spsy_reg, zf_reg);
            g_reg[6] <= qmul(cp_reg, zf_reg);
            g_reg[7] <= qmul(sp_reg, xf_reg);
            fg_reg <= ff_reg;
        end
    end
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vg_reg <= 1'b0;
        else if (en)
            vg_reg <= vf_f_reg;
    end

    function automatic logic [15:0] to_q15(input val_t v);
        val_t r;
        begin
            if (FRAC_BITS >= 15)
                r = v >>> (FRAC_BITS - 15);
            else
                r = v <<< (15 - FRAC_BITS);
            if (r > val_t'(32767)) r = val_t'(32767);
            if (r < -val_t'(32768)) r = -val_t'(32768);
            return r[15:0];
        end
    endfunction

    // Stage H: sums and saturation
    logic [15:0] ox_reg, oy_reg, oz_reg;
    logic of_reg, ov_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ov_reg <= 1'b0;
        else if (en)
            ov_reg <= vg_reg;
    end
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ox_reg <= to_q15(g_reg[0] - g_reg[1] + g_reg[2]);
            oy_reg <= to_q15(g_reg[3] + g_reg[4] + g_reg[5]);
            oz_reg <= to_q15(g_reg[6] - g_reg[7]);
            of_reg <= fg_reg;
        end
    end

    assign out_valid    = ov_reg;
    assign dir_x        = ox_reg;
    assign dir_y        = oy_reg;
    assign dir_z        = oz_reg;
    assign final_vector = of_reg;

endmodule

// ===== design/dds_frame.sv =====
// Frame terms of the normal: pitch cosine by root, yaw by two CORDIC passes.
module dds_frame
    import dds_pkg::*;
#(
    parameter int FRAC_BITS    = 15,
    parameter int CORDIC_STEPS = 16
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic signed [2*FRAC_BITS+7:0] nx,
    input  logic signed [2*FRAC_BITS+7:0] ny,
    input  logic signed [2*FRAC_BITS+7:0] nz,
    output logic signed [2*FRAC_BITS+7:0] cp,
    output logic signed [2*FRAC_BITS+7:0] sp,
    output logic signed [2*FRAC_BITS+7:0] cy,
    output logic signed [2*FRAC_BITS+7:0] sy
);
    // Free-running pipeline over the quiet configuration; its outputs settle
    // long before any item can reach the stage that reads them.
    localparam int W  = 2 * FRAC_BITS + 8;
    localparam int CS = CORDIC_STEPS;
    localparam logic signed [W-1:0] ONE = W'(1) <<< FRAC_BITS;
    typedef logic signed [W-1:0] val_t;

    // a normal component lies in [-1, 1], so F+2 bits per operand suffice
    function automatic logic signed [2*W-1:0] qprod(input val_t a, input val_t b);
        logic signed [FRAC_BITS+1:0]   an;
        logic signed [FRAC_BITS+1:0]   bn;
        logic signed [2*FRAC_BITS+3:0] p;
        begin
            an = a[FRAC_BITS+1:0];
            bn = b[FRAC_BITS+1:0];
            p  = an * bn;
            return (2*W)'(p);
        end
    endfunction

    logic signed [2*W-1:0] t_c;
    logic [63:0] rad;
    logic [31:0] cp_root;
    logic [0:0]  dummy;
    assign t_c = ONE * ONE - qprod(nz, nz);
    assign rad = (t_c > 0) ? 64'(t_c) : 64'd0;
    dds_sqrt #(.TAG_W(1)) u_sq (
        .clk(clk), .rst_n(rst_n), .en(1'b1), .radicand(rad), .tag_in(1'b0),
        .root(cp_root), .tag_out(dummy)
    );
    assign cp = val_t'({1'b0, cp_root});
    assign sp = -nz;

    val_t        ax_reg [CS+1];
    val_t        ay_reg [CS+1];
    logic [31:0] az_reg [CS+1];
    logic        zero0, zero_reg [CS+1];
    always_comb
    begin
        zero0 = (nx == 0) && (ny == 0);
        ax_reg[0] = (nx < 0) ? -nx : nx;
        ay_reg[0] = (nx < 0) ? -ny : ny;
        az_reg[0] = (nx < 0) ? 32'h80000000 : 32'h0;
        zero_reg[0] = zero0;
    end
    for (genvar i = 0; i < CS; i++)
    begin : g_vec
        localparam int S = i % 32;
        always_ff @(posedge clk)
        begin
            if (ay_reg[i] >= 0)
            begin
                ax_reg[i+1] <= ax_reg[i] + (ay_reg[i] >>> S);
                ay_reg[i+1] <= ay_reg[i] - (ax_reg[i] >>> S);
                az_reg[i+1] <= az_reg[i] + atan_entry(S);
            end
            else
            begin
                ax_reg[i+1] <= ax_reg[i] - (ay_reg[i] >>> S);
                ay_reg[i+1] <= ay_reg[i] + (ax_reg[i] >>> S);
                az_reg[i+1] <= az_reg[i] - atan_entry(S);
            end
            zero_reg[i+1] <= zero_reg[i];
        end
    end

    val_t              bx_reg [CS+1];
    val_t              by_reg [CS+1];
    logic signed [33:0] bd_reg [CS+1];
    logic              bfl_reg [CS+1];
    logic              bz_reg [CS+1];
    logic signed [33:0] d0;
    localparam val_t K0 = val_t'((64'h9B74EDA8 + (64'd1 << (31 - FRAC_BITS)))
                                 >> (32 - FRAC_BITS));
    always_comb
    begin
        d0 = 34'($signed(az_reg[CS]));
        bfl_reg[0] = 1'b0;
        if (d0 > 34'sh40000000)
        begin
            d0 = d0 - 34'sh80000000;
            bfl_reg[0] = 1'b1;
        end
        else if (d0 < -34'sh40000000)
        begin
            d0 = d0 + 34'sh80000000;
            bfl_reg[0] = 1'b1;
        end
        bd_reg[0] = d0;
        bx_reg[0] = K0;
        by_reg[0] = '0;
        bz_reg[0] = zero_reg[CS];
    end
    for (genvar i = 0; i < CS; i++)
    begin : g_rot
        localparam int S = i % 32;
        localparam logic signed [33:0] A = 34'(atan_entry(S));
        always_ff @(posedge clk)
        begin
            if (bd_reg[i] >= 0)
            begin
                bx_reg[i+1] <= bx_reg[i] - (by_reg[i] >>> S);
                by_reg[i+1] <= by_reg[i] + (bx_reg[i] >>> S);
                bd_reg[i+1] <= bd_reg[i] - A;
            end
            else
            begin
                bx_reg[i+1] <= bx_reg[i] + (by_reg[i] >>> S);
                by_reg[i+1] <= by_reg[i] - (bx_reg[i] >>> S);
                bd_reg[i+1] <= bd_reg[i] + A;
            end
            bfl_reg[i+1] <= bfl_reg[i];
            bz_reg[i+1]  <= bz_reg[i];
        end
    end

    val_t c_t, s_t;
    always_comb
    begin
        c_t = bfl_reg[CS] ? -bx_reg[CS] : bx_reg[CS];
        s_t = bfl_reg[CS] ? -by_reg[CS] : by_reg[CS];
        if (c_t > ONE) c_t = ONE;
        if (c_t < -ONE) c_t = -ONE;
        if (s_t > ONE) s_t = ONE;
        if (s_t < -ONE) s_t = -ONE;
        cy = bz_reg[CS] ? ONE : c_t;
        sy = bz_reg[CS] ? val_t'(0) : s_t;
    end

endmodule

// ===== design/dds_front.sv =====
// Front end: accepts items into a short queue that feeds the back pipeline.
module dds_front
    import dds_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      s_valid,
    output logic      s_ready,
    input  dds_item_t s_item,
    output logic      q_valid,
    input  logic      q_take,
    output dds_item_t q_item
);
    localparam int DEPTH = 2;

    dds_item_t  mem_reg [DEPTH];
    logic       wp_reg, rp_reg;
    logic [1:0] cnt_reg;
    logic       push, pop;

    assign s_ready = (cnt_reg != 2'(DEPTH));
    assign q_valid = (cnt_reg != 2'd0);
    assign q_item  = mem_reg[rp_reg];
    assign push    = s_valid && s_ready;
    assign pop     = q_valid && q_take;

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wp_reg] <= s_item;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            if (push) wp_reg <= ~wp_reg;
            if (pop)  rp_reg <= ~rp_reg;
            cnt_reg <= cnt_reg + 2'(push) - 2'(pop);
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n) cnt_reg <= 2'(DEPTH))
        else $error("queue overfilled");
    assert property (@(posedge clk) disable iff (!rst_n)
        (cnt_reg == 2'd0) |-> !pop)
        else $error("pop from empty queue");
    assert property (@(posedge clk) disable iff (!rst_n)
        (push && !pop) |=> (cnt_reg == $past(cnt_reg) + 2'd1))
        else $error("queue count slip");

endmodule

// ===== design/diffuse_direction_sampler.sv =====
// Top level of the diffuse direction sampler.
// Takes one item per cycle while the output is not stalled; each item passes
// through two 32-stage root units, two CORDIC chains and four product and sum
// stages in series before its direction appears on the output. The whole
// pipeline advances only when its output register is free, so a stalled output
// holds everything; a two-item queue in front absorbs up to two more items before
// s_tready drops. Write the normal only while no item is in flight; the write
// applies to every item accepted after it, since the frame terms settle
// through the frame's root unit and CORDIC chains long before such an item
// reaches them.
module diffuse_direction_sampler
    import dds_pkg::*;
#(
    parameter int FRAC_BITS    = 15,
    parameter int CORDIC_STEPS = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // rand_polar[15:0], rand_turn[31:16]
    input  logic        s_tlast,   // final_sample
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // dir_x[15:0], dir_y[31:16], dir_z[47:32]
    output logic        m_tlast,   // final_vector
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data
);
    logic [15:0] normal_x_reg, normal_y_reg, normal_z_reg;

    assign cfg_ready = 1'b1;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            normal_x_reg <= 16'h7FFF;
            normal_y_reg <= 16'h0000;
            normal_z_reg <= 16'h0000;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_NORMAL_X: normal_x_reg <= cfg_data;
                REG_NORMAL_Y: normal_y_reg <= cfg_data;
                REG_NORMAL_Z: normal_z_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    dds_item_t s_item, q_item;
    logic      q_valid, en, core_valid;
    assign s_item = '{rand_polar: s_tdata[15:0], rand_turn: s_tdata[31:16],
                      final_sample: s_tlast};

    // pipeline moves when the output slot is empty or being taken
    assign en = !m_tvalid || m_tready;

    dds_front u_front (
        .clk(clk), .rst_n(rst_n), .s_valid(s_tvalid), .s_ready(s_tready),
        .s_item(s_item), .q_valid(q_valid), .q_take(en), .q_item(q_item)
    );

    logic [15:0] dx, dy, dz;
    logic        fv;
    dds_core #(.FRAC_BITS(FRAC_BITS), .CORDIC_STEPS(CORDIC_STEPS)) u_core (
        .clk(clk), .rst_n(rst_n), .en(en), .in_valid(q_valid), .item(q_item),
        .normal_x(normal_x_reg), .normal_y(normal_y_reg), .normal_z(normal_z_reg),
        .out_valid(core_valid), .dir_x(dx), .dir_y(dy), .dir_z(dz),
        .final_vector(fv)
    );

    assign m_tvalid = core_valid;
    assign m_tdata  = {dz, dy, dx};
    assign m_tlast  = fv;

    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> m_tvalid)
        else $error("output item dropped while stalled");
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> $stable(m_tdata))
        else $error("output data changed while stalled");
    assert property (@(posedge clk) disable iff (!rst_n) cfg_ready)
        else $error("config port not ready");

endmodule
